// ===== design/vqdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Virtqueue descriptor chain manager package
// Shared sizes, codes and field widths of the descriptor free list block.
// ----------------------------------------------------------------------------
`default_nettype none

package vqdcm_pkg;

   localparam int QUEUE_DEPTH = 256;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int LEN_W       = 3;
   localparam int MASK_W      = 4;
   localparam int MAX_CHAIN   = 4;
   localparam int K_W         = $clog2(MAX_CHAIN);
   localparam int FLAG_W      = 2;
   localparam int ENTRY_W     = IDX_W + FLAG_W;
   localparam int CURSOR_W    = 16;
   localparam int STATUS_W    = 2;

   // Bit positions of the descriptor flags.
   localparam int FLAG_NEXT_BIT  = 0;
   localparam int FLAG_WRITE_BIT = 1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ALLOCATED = 2'd0,
      STATUS_REFUSED   = 2'd1,
      STATUS_FREED     = 2'd2
   } status_type;

   typedef enum logic {
      KIND_ALLOCATE = 1'b0,
      KIND_COMPLETE = 1'b1
   } kind_type;

endpackage

`default_nettype wire

// ===== design/vqdcm_if.sv =====
// ----------------------------------------------------------------------------
// Virtqueue descriptor chain manager channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface vqdcm_req_if;
   import vqdcm_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [LEN_W-1:0]  chain_length;
   logic [MASK_W-1:0] writable_mask;
   logic [IDX_W-1:0]  used_head;

   modport source (output valid, kind, chain_length, writable_mask, used_head,
                   input ready);
   modport sink   (input valid, kind, chain_length, writable_mask, used_head,
                   output ready);
endinterface

interface vqdcm_rsp_if;
   import vqdcm_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    desc_index;
   logic                has_next;
   logic                device_writes;
   logic [IDX_W-1:0]    ring_slot;
   logic [CNT_W-1:0]    freed_count;
   logic [CNT_W-1:0]    free_left;
   logic                last;

   modport source (output valid, status, desc_index, has_next, device_writes,
                   ring_slot, freed_count, free_left, last,
                   input ready);
   modport sink   (input valid, status, desc_index, has_next, device_writes,
                   ring_slot, freed_count, free_left, last,
                   output ready);
endinterface

`default_nettype wire

// ===== design/virtqueue_descriptor_chain_manager_core.sv =====
// An allocate item gives one result per cycle, one per descriptor of its chain,
// while the response channel is not stalled, and no new item is accepted until
// its last result. A refusal or a completion gives one result; a completion
// walks one descriptor per cycle through the descriptor RAM. Reset starts a
// pass that rebuilds the free list in the RAM, one entry per cycle, during
// which no item is accepted.
// ----------------------------------------------------------------------------
// Virtqueue descriptor chain manager core
// Keeps the descriptor table as a linked free list in one RAM of link and
// flag fields, allocates chains from the free head and returns used chains.
// ----------------------------------------------------------------------------
`default_nettype none

module virtqueue_descriptor_chain_manager_core (
   input wire logic   clock,
   input wire logic   reset,
   vqdcm_req_if.sink  req_chan,
   vqdcm_rsp_if.source rsp_chan
);
   import vqdcm_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_FREE,
      ST_REPLY
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  free_head_ff, free_head_in;
   logic [CNT_W-1:0]  free_total_ff, free_total_in;
   logic [CURSOR_W-1:0] avail_ff, avail_in;
   logic [CURSOR_W-1:0] used_ff, used_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   kind_type          kind_ff, kind_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  freed_ff, freed_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_next_ff, rsp_next_in;
   logic              rsp_write_ff, rsp_write_in;
   logic [IDX_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [CNT_W-1:0]  rsp_freed_ff, rsp_freed_in;
   logic [CNT_W-1:0]  rsp_left_ff, rsp_left_in;
   logic              rsp_last_ff, rsp_last_in;

   logic               fwd_hit_ff, fwd_hit_in;
   logic [ENTRY_W-1:0] fwd_data_ff;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] entry;
   logic [IDX_W-1:0]   link;
   logic [FLAG_W-1:0]  flags;
   logic               out_free;
   logic               is_last;
   logic [LEN_W-1:0]   len_sel;

   vqdcm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cur_in),
      .rd_data (rd_data)
   );

   // The RAM is read every cycle at the next current descriptor, so its data
   // always belongs to cur_ff; a write to that entry in the same cycle is
   // forwarded around the RAM.
   assign entry = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign link  = entry[IDX_W-1:0];
   assign flags = entry[ENTRY_W-1:IDX_W];

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_last  = (LEN_W'(k_ff) + LEN_W'(1)) == len_ff;
   assign fwd_hit_in = wr_en && (wr_addr == cur_in);

   always_comb begin
      priority if (req_chan.chain_length == '0) begin
         len_sel = LEN_W'(1);
      end else if (req_chan.chain_length > LEN_W'(MAX_CHAIN)) begin
         len_sel = LEN_W'(MAX_CHAIN);
      end else begin
         len_sel = req_chan.chain_length;
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      free_head_in  = free_head_ff;
      free_total_in = free_total_ff;
      avail_in      = avail_ff;
      used_in       = used_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      mask_in       = mask_ff;
      slot_in       = slot_ff;
      kind_in       = kind_ff;
      head_in       = head_ff;
      freed_in      = freed_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_write_in  = rsp_write_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_last_in   = rsp_last_ff;

      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = entry;

      unique case (state_ff)
         ST_CLEAR: begin
            // Rebuild the reset free list: entry i links to i minus one.
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {FLAG_W'(0), clr_ff - IDX_W'(1)};
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               kind_in  = kind_type'(req_chan.kind);
               head_in  = req_chan.used_head;
               len_in   = len_sel;
               mask_in  = req_chan.writable_mask;
               freed_in = '0;
               if (req_chan.kind == KIND_COMPLETE) begin
                  cur_in = req_chan.used_head;
                  if (free_total_ff == CNT_W'(QUEUE_DEPTH)) begin
                     state_in = ST_REPLY;
                  end else begin
                     state_in = ST_FREE;
                  end
               end else if (free_total_ff < CNT_W'(len_sel)) begin
                  state_in = ST_REPLY;
               end else begin
                  free_total_in = free_total_ff - CNT_W'(len_sel);
                  cur_in        = free_head_ff;
                  k_in          = '0;
                  slot_in       = avail_ff[IDX_W-1:0];
                  state_in      = ST_ALLOC;
               end
            end
         end
         ST_ALLOC: begin
            if (out_free) begin
               wr_en         = 1'b1;
               wr_data       = {mask_ff[k_ff], !is_last, link};
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_ALLOCATED;
               rsp_index_in  = cur_ff;
               rsp_next_in   = !is_last;
               rsp_write_in  = mask_ff[k_ff];
               rsp_slot_in   = slot_ff;
               rsp_freed_in  = '0;
               rsp_left_in   = free_total_ff;
               rsp_last_in   = is_last;
               if (is_last) begin
                  free_head_in = link;
                  avail_in     = avail_ff + CURSOR_W'(1);
                  state_in     = ST_IDLE;
               end else begin
                  k_in   = k_ff + K_W'(1);
                  cur_in = link;
               end
            end
         end
         ST_FREE: begin
            // Push the descriptor on the free list; its old link is the chain.
            wr_en         = 1'b1;
            wr_data       = {flags, free_head_ff};
            free_head_in  = cur_ff;
            free_total_in = free_total_ff + CNT_W'(1);
            freed_in      = freed_ff + CNT_W'(1);
            cur_in        = link;
            if (!flags[FLAG_NEXT_BIT] || free_total_ff == CNT_W'(QUEUE_DEPTH - 1)) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_next_in  = 1'b0;
               rsp_write_in = 1'b0;
               rsp_left_in  = free_total_ff;
               rsp_last_in  = 1'b1;
               if (kind_ff == KIND_COMPLETE) begin
                  rsp_status_in = STATUS_FREED;
                  rsp_index_in  = head_ff;
                  rsp_slot_in   = used_ff[IDX_W-1:0];
                  rsp_freed_in  = freed_ff;
                  used_in       = used_ff + CURSOR_W'(1);
               end else begin
                  rsp_status_in = STATUS_REFUSED;
                  rsp_index_in  = '0;
                  rsp_slot_in   = '0;
                  rsp_freed_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         free_head_ff  <= IDX_W'(QUEUE_DEPTH - 1);
         free_total_ff <= CNT_W'(QUEUE_DEPTH);
         avail_ff      <= '0;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_head_ff  <= free_head_in;
         free_total_ff <= free_total_in;
         avail_ff      <= avail_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_hit_ff    <= fwd_hit_in;
      end
      cur_ff        <= cur_in;
      len_ff        <= len_in;
      k_ff          <= k_in;
      mask_ff       <= mask_in;
      slot_ff       <= slot_in;
      kind_ff       <= kind_in;
      head_ff       <= head_in;
      freed_ff      <= freed_in;
      fwd_data_ff   <= wr_data;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_write_ff  <= rsp_write_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.desc_index    = rsp_index_ff;
   assign rsp_chan.has_next      = rsp_next_ff;
   assign rsp_chan.device_writes = rsp_write_ff;
   assign rsp_chan.ring_slot     = rsp_slot_ff;
   assign rsp_chan.freed_count   = rsp_freed_ff;
   assign rsp_chan.free_left     = rsp_left_ff;
   assign rsp_chan.last          = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/vqdcm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vqdcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/vqdcm_checker.sv =====
// ----------------------------------------------------------------------------
// Virtqueue descriptor chain manager checker
// Port-level assertions on the response channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module vqdcm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [vqdcm_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [vqdcm_pkg::IDX_W-1:0]    rsp_desc_index,
   input wire logic                          rsp_has_next,
   input wire logic                          rsp_device_writes,
   input wire logic [vqdcm_pkg::CNT_W-1:0]    rsp_freed_count,
   input wire logic                          rsp_last
);
   import vqdcm_pkg::*;

   // A stalled item keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_desc_index) && $stable(rsp_last))
      else $error("response item changed while stalled");

   // A refusal is a single, empty item.
   a_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_REFUSED |-> rsp_last
         && rsp_desc_index == '0 && rsp_freed_count == '0 && !rsp_has_next)
      else $error("malformed refusal item");

   // Within an allocated chain, the next flag is set on every item but the last.
   a_alloc_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ALLOCATED |-> rsp_has_next != rsp_last
         && rsp_freed_count == '0)
      else $error("allocated item has inconsistent next flag");

   // A completion is a single item with no descriptor flags.
   a_freed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FREED |-> rsp_last && !rsp_has_next
         && !rsp_device_writes)
      else $error("malformed completion item");

   // Never the unused status code.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_ALLOCATED || rsp_status == STATUS_REFUSED
         || rsp_status == STATUS_FREED)
      else $error("response carries an unused status code");

endmodule

bind virtqueue_descriptor_chain_manager_core vqdcm_checker u_vqdcm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_desc_index    (rsp_chan.desc_index),
   .rsp_has_next      (rsp_chan.has_next),
   .rsp_device_writes (rsp_chan.device_writes),
   .rsp_freed_count   (rsp_chan.freed_count),
   .rsp_last          (rsp_chan.last)
);

`default_nettype wire
